[hdl/kbt_pkg.sv]
// Shared types and constants for the Kronecker butterfly transform core.
// No dependencies; used by kbt_bfly and kronecker_butterfly_transform_core.
package kbt_pkg;

  localparam int LogPoints = 10;
  localparam int NumPoints = 1 << LogPoints;
  localparam int NumPairs  = NumPoints / 2;
  localparam int IdxW      = LogPoints;
  localparam int PairW     = (LogPoints > 1) ? LogPoints - 1 : 1;
  localparam int DataW     = 32;
  localparam int WeightW   = 16;
  localparam int DiffW     = DataW + 1;
  localparam int ProdW     = DiffW + WeightW + 1;
  localparam int RndW      = ProdW - WeightW;
  localparam int ActW      = 2;

  localparam logic [WeightW-1:0] MixReset = 16'd6554;
  localparam logic [ProdW-1:0]   RndHalf  = ProdW'(32768);

  typedef enum logic [ActW-1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIFF,
    ST_MUL,
    ST_RND,
    ST_WA,
    ST_WB,
    ST_DONE
  } st_e;

  // step enables for the shared butterfly unit
  typedef struct packed {
    logic load_diff;
    logic load_prod;
    logic load_rnd;
  } bfly_ctrl_t;

endpackage

[hdl/kbt_bfly.sv]
// Shared butterfly unit: difference, weighted product, rounding, updated pair.
// Depends on kbt_pkg; stepped by the sequencer in the top level.
module kbt_bfly (
  input  logic                               clk_i,
  input  kbt_pkg::bfly_ctrl_t                ctrl_i,
  input  logic        [kbt_pkg::WeightW-1:0] weight_i,
  input  logic signed [kbt_pkg::DataW-1:0]   a_i,
  input  logic signed [kbt_pkg::DataW-1:0]   b_i,
  output logic signed [kbt_pkg::DataW-1:0]   new_a_o,
  output logic signed [kbt_pkg::DataW-1:0]   new_b_o
);

  logic signed [kbt_pkg::DiffW-1:0] diff_q, diff_d;
  logic signed [kbt_pkg::ProdW-1:0] prod_q, prod_d, prod_rnd;
  logic signed [kbt_pkg::RndW-1:0]  rnd_q, rnd_d;
  logic signed [kbt_pkg::RndW-1:0]  sum_a, sum_b;

  // b - a at full width
  assign diff_d = kbt_pkg::DiffW'(b_i) - kbt_pkg::DiffW'(a_i);

  // unsigned weight times signed difference
  assign prod_d = kbt_pkg::ProdW'(diff_q) *
                  $signed(kbt_pkg::ProdW'({1'b0, weight_i}));

  // round half up at bit 16
  assign prod_rnd = prod_q + kbt_pkg::RndHalf;
  assign rnd_d    = prod_rnd[kbt_pkg::ProdW-1:kbt_pkg::WeightW];

  // convex mix never leaves the sample width
  assign sum_a   = kbt_pkg::RndW'(a_i) + rnd_q;
  assign sum_b   = kbt_pkg::RndW'(b_i) - rnd_q;
  assign new_a_o = sum_a[kbt_pkg::DataW-1:0];
  assign new_b_o = sum_b[kbt_pkg::DataW-1:0];

  // hold each intermediate until its step comes again
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_diff) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.load_prod) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.load_rnd) begin
      rnd_q <= rnd_d;
    end
  end

endmodule

[hdl/kronecker_butterfly_transform_core.sv]
// Top level of the Kronecker butterfly transform core: sample store, sequencer,
// output register. Depends on kbt_pkg and kbt_bfly.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries action, sample_index and
//   sample_value. Action 0 writes a sample, 1 transforms the whole store in
//   place, 2 reads a sample, 3 does nothing. Every item yields one result on
//   the output channel (out_valid_o / out_stall_i); only reads set is_read_o.
//   The user must write the weight register (cfg_valid_i / cfg_data_i) only while
//   idle; the core itself does not enforce this.
//   Write and no-op items load their result in the cycle they are taken; reads go
//   through ST_READ for the registered store read. A run steps each butterfly
//   through ST_LOAD, ST_DIFF, ST_MUL, ST_RND, ST_WA and ST_WB in turn: one shared
//   butterfly unit and one store write port. One item is in work at a time.
// Reset and stall:
//   Reset clears the sequencer, the output valid and sets the weight to 6554;
//   the store is undefined until written. A new item is taken while a finished
//   result is leaving; while the receiver stalls a held result, in_stall_o is high.
module kronecker_butterfly_transform_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic        [kbt_pkg::WeightW-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic        [kbt_pkg::ActW-1:0]  action_i,
  input  logic        [kbt_pkg::IdxW-1:0]  sample_index_i,
  input  logic signed [kbt_pkg::DataW-1:0] sample_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [kbt_pkg::DataW-1:0] read_value_o,
  output logic                             is_read_o
);

  kbt_pkg::st_e       state_q, state_d;
  kbt_pkg::bfly_ctrl_t bfly_ctrl;

  logic [kbt_pkg::WeightW-1:0] weight_q;
  logic [kbt_pkg::PairW-1:0]   pair_q, pair_d;
  logic [kbt_pkg::IdxW-1:0]    span_q, span_d;
  logic [kbt_pkg::IdxW-1:0]    pair_x, span_mask, idx_a, idx_b;
  logic [kbt_pkg::IdxW-1:0]    rd_addr_a, rd_addr_b, wr_addr;

  logic [kbt_pkg::DataW-1:0]        mem_q [kbt_pkg::NumPoints];
  logic signed [kbt_pkg::DataW-1:0] rd_a_q, rd_b_q;
  logic signed [kbt_pkg::DataW-1:0] wr_data, new_a, new_b;
  logic                             wr_en, rd_en;

  logic                             out_valid_q, out_valid_d;
  logic signed [kbt_pkg::DataW-1:0] out_value_q, out_value_d;
  logic                             out_is_read_q, out_is_read_d;
  logic                             out_load;
  logic                             in_ready, in_xfer;
  logic                             last_pair, last_pass;

  assign cfg_ready_o = 1'b1;

  // take a new item only when idle and the output slot is empty or frees this cycle
  assign in_ready   = (state_q == kbt_pkg::ST_IDLE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !in_ready;
  assign in_xfer    = in_valid_i && in_ready;

  // pair addresses: insert a zero at the span bit of the pair counter
  assign pair_x    = kbt_pkg::IdxW'(pair_q);
  assign span_mask = span_q - kbt_pkg::IdxW'(1);
  assign idx_a     = ((pair_x & ~span_mask) << 1) | (pair_x & span_mask);
  assign idx_b     = idx_a | span_q;
  assign last_pair = (pair_q == kbt_pkg::PairW'(kbt_pkg::NumPairs - 1));
  assign last_pass = span_q[kbt_pkg::IdxW-1];

  kbt_bfly u_bfly (
    .clk_i    (clk_i),
    .ctrl_i   (bfly_ctrl),
    .weight_i (weight_q),
    .a_i      (rd_a_q),
    .b_i      (rd_b_q),
    .new_a_o  (new_a),
    .new_b_o  (new_b)
  );

  // sequencer: next state, store access, butterfly steps, result load
  always_comb begin
    state_d       = state_q;
    pair_d        = pair_q;
    span_d        = span_q;
    bfly_ctrl     = '0;
    rd_en         = 1'b0;
    rd_addr_a     = idx_a;
    rd_addr_b     = idx_b;
    wr_en         = 1'b0;
    wr_addr       = idx_a;
    wr_data       = new_a;
    out_load      = 1'b0;
    out_value_d   = '0;
    out_is_read_d = 1'b0;
    case (state_q)
      kbt_pkg::ST_IDLE: begin
        rd_addr_a = sample_index_i;
        wr_addr   = sample_index_i;
        wr_data   = sample_value_i;
        if (in_xfer) begin
          case (kbt_pkg::act_e'(action_i))
            kbt_pkg::ACT_WRITE: begin
              wr_en    = 1'b1;
              out_load = 1'b1;
            end
            kbt_pkg::ACT_RUN: begin
              pair_d  = '0;
              span_d  = kbt_pkg::IdxW'(1);
              state_d = kbt_pkg::ST_LOAD;
            end
            kbt_pkg::ACT_READ: begin
              rd_en   = 1'b1;
              state_d = kbt_pkg::ST_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      kbt_pkg::ST_READ: begin
        out_load      = 1'b1;
        out_value_d   = rd_a_q;
        out_is_read_d = 1'b1;
        state_d       = kbt_pkg::ST_IDLE;
      end
      kbt_pkg::ST_LOAD: begin
        rd_en   = 1'b1;
        state_d = kbt_pkg::ST_DIFF;
      end
      kbt_pkg::ST_DIFF: begin
        bfly_ctrl.load_diff = 1'b1;
        state_d             = kbt_pkg::ST_MUL;
      end
      kbt_pkg::ST_MUL: begin
        bfly_ctrl.load_prod = 1'b1;
        state_d             = kbt_pkg::ST_RND;
      end
      kbt_pkg::ST_RND: begin
        bfly_ctrl.load_rnd = 1'b1;
        state_d            = kbt_pkg::ST_WA;
      end
      kbt_pkg::ST_WA: begin
        wr_en   = 1'b1;
        state_d = kbt_pkg::ST_WB;
      end
      kbt_pkg::ST_WB: begin
        wr_en   = 1'b1;
        wr_addr = idx_b;
        wr_data = new_b;
        state_d = kbt_pkg::ST_LOAD;
        pair_d  = pair_q + kbt_pkg::PairW'(1);
        if (last_pair) begin
          pair_d = '0;
          span_d = span_q << 1;
          if (last_pass) begin
            state_d = kbt_pkg::ST_DONE;
          end
        end
      end
      kbt_pkg::ST_DONE: begin
        out_load = 1'b1;
        state_d  = kbt_pkg::ST_IDLE;
      end
      default: begin
        state_d = kbt_pkg::ST_IDLE;
      end
    endcase
  end

  // state and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kbt_pkg::ST_IDLE;
      pair_q  <= '0;
      span_q  <= kbt_pkg::IdxW'(1);
    end else begin
      state_q <= state_d;
      pair_q  <= pair_d;
      span_q  <= span_d;
    end
  end

  // weight register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= kbt_pkg::MixReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      weight_q <= cfg_data_i;
    end
  end

  // sample store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[rd_addr_b];
    end
  end

  // output register: load a result, drop it once transferred
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q   <= out_value_d;
      out_is_read_q <= out_is_read_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign is_read_o    = out_is_read_q;

endmodule

[verif/kbt_result_checker.sv]
// Result checker for the Kronecker butterfly transform core: mirrors the sample
// store and the mix weight, predicts one result per input transfer and compares.
// Depends on kbt_pkg for widths, reset weight and action codes.
module kbt_result_checker
  import kbt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic        [WeightW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic        [ActW-1:0]    action_i,
  input  logic        [IdxW-1:0]    sample_index_i,
  input  logic signed [DataW-1:0]   sample_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [DataW-1:0]   read_value_i,
  input  logic                      is_read_i,
  output int                        mismatch_count_o,
  output int                        pending_count_o
);

  typedef struct {
    logic signed [DataW-1:0] read_value;
    logic                    is_read;
  } sample_result_t;

  logic signed [DataW-1:0] sample_mirror [NumPoints];
  logic        [WeightW-1:0] mix_weight_q;
  sample_result_t          awaited_results [$];

  // Apply every radix-2 pass in place, spans 1, 2, 4, ...
  function automatic void mix_all_pairs();
    longint a, b, r, w;
    int     span;
    int     i;
    w = longint'(mix_weight_q);
    for (span = 1; span < NumPoints; span = span << 1) begin
      for (i = 0; i < NumPoints; i++) begin
        if ((i & span) == 0) begin
          a = longint'(sample_mirror[IdxW'(i)]);
          b = longint'(sample_mirror[IdxW'(i + span)]);
          // round half up at bit 16: add half an LSB, then floor
          r = (w * (b - a) + 64'sd32768) >>> 16;
          sample_mirror[IdxW'(i)]        = DataW'(a + r);
          sample_mirror[IdxW'(i + span)] = DataW'(b - r);
        end
      end
    end
  endfunction

  // Update the mirror for one item and return the result it should produce
  function automatic sample_result_t apply_item(act_e act, logic [IdxW-1:0] idx,
                                                logic signed [DataW-1:0] val);
    sample_result_t res;
    res.read_value = '0;
    res.is_read    = 1'b0;
    case (act)
      ACT_WRITE: sample_mirror[idx] = val;
      ACT_RUN:   mix_all_pairs();
      ACT_READ: begin
        res.read_value = sample_mirror[idx];
        res.is_read    = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_result_t want;
    if (!rst_ni) begin
      mix_weight_q = MixReset;
      awaited_results.delete();
      mismatch_count_o = 0;
    end else begin
      // check a result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got read_value %0d is_read %0b",
                   $time, read_value_i, is_read_i);
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (read_value_i !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %0d, got %0d",
                     $time, want.read_value, read_value_i);
            mismatch_count_o++;
          end
          if (is_read_i !== want.is_read) begin
            $display("%0t: is_read mismatch, expected %0b, got %0b",
                     $time, want.is_read, is_read_i);
            mismatch_count_o++;
          end
        end
      end
      // track weight writes
      if (cfg_valid_i && cfg_ready_i) begin
        mix_weight_q = cfg_data_i;
      end
      // predict for an input transfer
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(apply_item(act_e'(action_i), sample_index_i,
                                             sample_value_i));
      end
    end
    pending_count_o = awaited_results.size();
  end

endmodule

[verif/tb_kronecker_butterfly_transform_core.sv]
// Testbench top for kronecker_butterfly_transform_core: drives clock, reset,
// weight writes and sample items, and gives the verdict.
// Depends on kbt_pkg, the core and kbt_result_checker.
module tb_kronecker_butterfly_transform_core;
  import kbt_pkg::*;

  localparam int QuietLimit = 150000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic        [WeightW-1:0] cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic        [ActW-1:0]    action_i;
  logic        [IdxW-1:0]    sample_index_i;
  logic signed [DataW-1:0]   sample_value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [DataW-1:0]   read_value_o;
  logic                      is_read_o;

  int mismatch_count;
  int pending_count;
  int src_idle_pct;
  int sink_idle_pct;
  int n_writes;
  int n_reads;
  int n_runs;
  int n_nops;
  logic [WeightW-1:0] last_weight;

  kronecker_butterfly_transform_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .sample_index_i (sample_index_i),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_value_o   (read_value_o),
    .is_read_o      (is_read_o)
  );

  kbt_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .action_i         (action_i),
    .sample_index_i   (sample_index_i),
    .sample_value_i   (sample_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_value_i     (read_value_o),
    .is_read_i        (is_read_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the result side at random; hold off once for a long stretch
  initial begin : result_sink
    int  taken;
    int  hold_left;
    bit  hold_done;
    taken       = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) taken++;
      if (!hold_done && taken == 30) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < sink_idle_pct);
      end
    end
  end

  // End the run if no transfer of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, quiet, pending_count);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 23))
      0:       return {1'b1, {(DataW-1){1'b0}}};
      1:       return {1'b0, {(DataW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one item after a random gap and hold it until the transfer.
  // Entered and left at a falling edge.
  task automatic send_item(input act_e act, input logic [IdxW-1:0] idx,
                           input logic signed [DataW-1:0] val);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    sample_index_i <= idx;
    sample_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    case (act)
      ACT_WRITE: n_writes++;
      ACT_READ:  n_reads++;
      ACT_RUN:   n_runs++;
      default:   n_nops++;
    endcase
  endtask

  // Drain all results, then write the weight while the core is idle
  task automatic write_weight(input logic [WeightW-1:0] w);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    last_weight = w;
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_item(ACT_WRITE, IdxW'($urandom_range(0, NumPoints - 1)), pick_value());
    end else if (pick < 93) begin
      send_item(ACT_READ, IdxW'($urandom_range(0, NumPoints - 1)), $urandom());
    end else begin
      send_item(ACT_NOP, IdxW'($urandom_range(0, NumPoints - 1)), $urandom());
    end
  endtask

  // Random mix with one transform at a random slot
  task automatic run_phase(input int n_items);
    int run_slot;
    int k;
    run_slot = $urandom_range(n_items / 4, 3 * n_items / 4);
    for (k = 0; k < n_items; k++) begin
      if (k == run_slot) begin
        send_item(ACT_RUN, IdxW'($urandom_range(0, NumPoints - 1)), $urandom());
      end else begin
        send_random_item();
      end
    end
  endtask

  initial begin : stimulus
    int fill;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    action_i       = ACT_NOP;
    sample_index_i = '0;
    sample_value_i = '0;
    n_writes       = 0;
    n_reads        = 0;
    n_runs         = 0;
    n_nops         = 0;
    last_weight    = MixReset;
    src_idle_pct   = 21;
    sink_idle_pct  = 80;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, write then read back, no-op
    send_item(ACT_WRITE, '0, {1'b1, {(DataW-1){1'b0}}});
    send_item(ACT_WRITE, IdxW'(NumPoints - 1), {1'b0, {(DataW-1){1'b1}}});
    send_item(ACT_WRITE, IdxW'(1), '0);
    send_item(ACT_WRITE, IdxW'(2), '1);
    send_item(ACT_WRITE, IdxW'(NumPoints / 2), 32'sd1);
    send_item(ACT_WRITE, 10'h155, 32'h5555_5555);
    send_item(ACT_READ, '0, '1);
    send_item(ACT_READ, IdxW'(NumPoints - 1), '0);
    send_item(ACT_READ, IdxW'(1), $urandom());
    send_item(ACT_READ, IdxW'(2), $urandom());
    send_item(ACT_READ, IdxW'(NumPoints / 2), $urandom());
    send_item(ACT_READ, 10'h155, $urandom());
    send_item(ACT_NOP, IdxW'(NumPoints - 1), '1);
    send_item(ACT_NOP, '0, '0);
    send_item(ACT_READ, '0, $urandom());
    send_item(ACT_WRITE, '0, 32'hA5A5_A5A5);
    send_item(ACT_READ, '0, $urandom());

    // fill the whole store so every transform reads written entries
    for (fill = 0; fill < NumPoints; fill++) begin
      send_item(ACT_WRITE, IdxW'(fill), pick_value());
      if ($urandom_range(0, 19) == 0) begin
        send_item(ACT_READ, IdxW'($urandom_range(0, fill)), $urandom());
      end
    end

    // transform at the reset weight, then spot reads
    send_item(ACT_RUN, '0, '0);
    send_item(ACT_READ, '0, $urandom());
    send_item(ACT_READ, IdxW'(NumPoints - 1), $urandom());
    run_phase(70);

    // weight zero leaves the store unchanged; swap the idle ratios
    src_idle_pct  = 80;
    sink_idle_pct = 21;
    write_weight('0);
    run_phase(70);

    // full weight, no idling on either side
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_weight('1);
    run_phase(60);

    write_weight(WeightW'($urandom_range(1, 65534)));
    run_phase(60);

    // drain and let the core settle
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("covered %0d writes, %0d reads, %0d transforms, %0d no-ops",
             n_writes, n_reads, n_runs, n_nops);
    $display("weights used: %0d at reset, 0, 65535 and %0d", MixReset, last_weight);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
hdl/kbt_pkg.sv
hdl/kbt_bfly.sv
hdl/kronecker_butterfly_transform_core.sv
verif/kbt_result_checker.sv
verif/tb_kronecker_butterfly_transform_core.sv
